>>> src/wes_pkg.sv
`default_nettype none
package wes_pkg;

	localparam int LEAF_COUNT    = 1024;
	localparam int WEIGHT_BITS   = 32;
	localparam int FRACTION_BITS = 32;

	// tree geometry (heap order, root at node 0, children 2k+1 / 2k+2)
	localparam int LEVELS     = $clog2(LEAF_COUNT);
	localparam int PADDED     = 1 << LEVELS;
	localparam int NODE_COUNT = 2 * PADDED - 1;
	localparam int NODE_AW    = $clog2(NODE_COUNT);
	localparam int SUM_BITS   = WEIGHT_BITS + LEVELS;
	localparam int CNT_BITS   = $clog2(LEAF_COUNT + 1);

	// fixed field widths
	localparam int OP_W    = 2;
	localparam int IDX_W   = 10;
	localparam int FIELD_W = 32;
	localparam int TOTAL_W = 42;
	localparam int COUNT_W = 11;

	localparam logic [NODE_AW-1:0] LEAF_BASE   = NODE_AW'(PADDED - 1);
	localparam logic [FIELD_W-1:0] WEIGHT_MASK = FIELD_W'((65'd1 << WEIGHT_BITS) - 65'd1);
	localparam logic [FIELD_W-1:0] FRAC_MASK   = FIELD_W'((65'd1 << FRACTION_BITS) - 65'd1);

	typedef enum logic [OP_W-1:0] {
		OP_SET    = 2'd0,
		OP_SELECT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [IDX_W-1:0]   leaf_index;
		logic [FIELD_W-1:0] weight;
		logic [FIELD_W-1:0] random_fraction;
	} req_t;

	typedef struct packed {
		logic               event_valid;
		logic [IDX_W-1:0]   event_index;
		logic [TOTAL_W-1:0] total_weight;
		logic [COUNT_W-1:0] active_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET_LEAF,
		ST_SET_UP,
		ST_MUL,
		ST_SCALE,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                done;
		logic [SUM_BITS-1:0] target;
	} scale_rsp_t;

endpackage
`default_nettype wire

>>> src/weighted_event_sum_tree.sv
// Set: leaf read, leaf write, then one level per cycle up to the root.
// Select: scaling in the shared multiplier, then one node memory read per level down.
// Clear sweeps all 2047 tree nodes, one per cycle, then answers.
// One request at a time; the next is taken once the previous result is in the output register.
// Reset (arst_n, async low) starts the same sweep of all 2047 nodes with req_ready low.
`default_nettype none
module weighted_event_sum_tree import wes_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	// control state
	state_t              state_q, state_d;
	logic [NODE_AW-1:0]  node_q;        // current tree node, also the sweep pointer
	logic                clr_reply_q;   // sweep came from a clear request, not reset
	logic [SUM_BITS-1:0] total_q;       // mirror of the root node
	logic [CNT_BITS-1:0] count_q;       // leaves above zero
	logic                ev_valid_q;
	logic                out_valid_q;
	rsp_t                out_q;

	// payload registers
	logic [FIELD_W-1:0]  weight_q;
	logic [FIELD_W-1:0]  frac_q;
	logic [SUM_BITS-1:0] acc_q;         // value of the node just written (set walk)
	logic [SUM_BITS-1:0] target_q;      // remaining target (select walk)

	// node memory, one write and one read port, read data registered
	logic [SUM_BITS-1:0] mem [NODE_COUNT];
	logic [SUM_BITS-1:0] rdata_q;
	logic                mem_we;
	logic [NODE_AW-1:0]  mem_waddr, mem_raddr;
	logic [SUM_BITS-1:0] mem_wdata;

	// datapath helpers
	logic                accept, idx_ok, out_free, go_left, mul_start;
	logic [NODE_AW-1:0]  leaf_addr, parent, parent_sib, node_sib, left, next_node;
	logic [SUM_BITS-1:0] up_sum;
	scale_rsp_t          scale_rsp;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign idx_ok    = 32'(req.leaf_index) < 32'(LEAF_COUNT);
	assign leaf_addr = LEAF_BASE + NODE_AW'(req.leaf_index);

	function automatic logic [NODE_AW-1:0] sibling(input logic [NODE_AW-1:0] n);
		sibling = n[0] ? n + NODE_AW'(1) : n - NODE_AW'(1);
	endfunction

	always_comb begin
		parent     = (node_q - NODE_AW'(1)) >> 1;
		parent_sib = sibling(parent);
		node_sib   = sibling(node_q);
		up_sum     = acc_q + rdata_q;
		left       = {node_q[NODE_AW-2:0], 1'b1};
		go_left    = target_q < rdata_q;
		next_node  = go_left ? left : left + NODE_AW'(1);
	end

	wes_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_start),
		.fraction (frac_q),
		.total    (total_q),
		.rsp      (scale_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (node_q == NODE_AW'(NODE_COUNT - 1))
					state_d = clr_reply_q ? ST_DONE : ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (req.operation)
						OP_SET:    state_d = idx_ok ? ST_SET_LEAF : ST_DONE;
						OP_SELECT: state_d = (total_q != '0) ? ST_MUL : ST_DONE;
						OP_CLEAR:  state_d = ST_CLEAR;
						OP_NOP:    state_d = ST_DONE;
					endcase
				end
			end
			ST_SET_LEAF: state_d = ST_SET_UP;
			ST_SET_UP:   if (parent == '0) state_d = ST_DONE;
			ST_MUL:      state_d = ST_SCALE;
			ST_SCALE:    if (scale_rsp.done) state_d = ST_WALK;
			ST_WALK:     if (next_node >= LEAF_BASE) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory controls; the set walk reads off-path siblings while writing the
	// path, so a read never hits the entry written in the same cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = node_q;
		mem_wdata = '0;
		mem_raddr = node_sib;
		mul_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_raddr = leaf_addr;
			end
			ST_SET_LEAF: begin
				mem_we    = 1'b1;
				mem_wdata = SUM_BITS'(weight_q);
			end
			ST_SET_UP: begin
				mem_we    = 1'b1;
				mem_waddr = parent;
				mem_wdata = up_sum;
				mem_raddr = parent_sib;
			end
			ST_MUL: begin
				mul_start = 1'b1;
			end
			ST_SCALE: begin
				mem_raddr = NODE_AW'(1);
			end
			ST_WALK: begin
				mem_raddr = {next_node[NODE_AW-2:0], 1'b1};
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			node_q      <= '0;
			clr_reply_q <= 1'b0;
			total_q     <= '0;
			count_q     <= '0;
			ev_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					node_q <= node_q + NODE_AW'(1);
				end
				ST_IDLE: begin
					ev_valid_q <= 1'b0;
					if (accept && req.operation == OP_CLEAR) begin
						node_q      <= '0;
						clr_reply_q <= 1'b1;
						total_q     <= '0;
						count_q     <= '0;
					end else begin
						node_q <= leaf_addr;
					end
				end
				ST_SET_LEAF: begin
					// rdata_q holds the old leaf weight
					count_q <= count_q - CNT_BITS'(rdata_q != '0)
					                   + CNT_BITS'(weight_q != '0);
				end
				ST_SET_UP: begin
					node_q <= parent;
					if (parent == '0) total_q <= up_sum;
				end
				ST_MUL: ;
				ST_SCALE: begin
					node_q <= '0;
				end
				ST_WALK: begin
					node_q <= next_node;
					if (next_node >= LEAF_BASE) ev_valid_q <= 1'b1;
				end
				ST_DONE: begin
					clr_reply_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			weight_q <= req.weight & WEIGHT_MASK;
			frac_q   <= req.random_fraction;
		end
		unique case (state_q)
			ST_SET_LEAF: acc_q <= SUM_BITS'(weight_q);
			ST_SET_UP:   acc_q <= up_sum;
			ST_SCALE:    target_q <= scale_rsp.target;
			ST_WALK:     if (!go_left) target_q <= target_q - rdata_q;
			default: ;
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_q.event_valid  <= ev_valid_q;
			out_q.event_index  <= ev_valid_q ? IDX_W'(node_q - LEAF_BASE) : '0;
			out_q.total_weight <= TOTAL_W'(total_q);
			out_q.active_count <= COUNT_W'(count_q);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_zero_total_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && total_q == '0) |-> count_q == '0)
		else $error("positive leaves with zero total");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(LEAF_COUNT))
		else $error("active count above leaf count");

	a_walk_inner: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> node_q < LEAF_BASE)
		else $error("select walk past leaf row");

	a_set_below_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SET_UP |-> node_q != '0)
		else $error("set walk above root");

endmodule
`default_nettype wire

>>> src/wes_scale.sv
`default_nettype none
// target = floor(r * total / 2^FRACTION_BITS), one shared 32x32 multiplier,
// low half then high half of the total, then the combine.
module wes_scale import wes_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [FIELD_W-1:0]  fraction,
	input  wire logic [SUM_BITS-1:0] total,
	output scale_rsp_t               rsp
);

	logic        lo_done_q, hi_done_q, done_q;
	logic [63:0] lo_q, hi_q;
	logic [SUM_BITS-1:0] target_q;

	logic [31:0] r_op, b_op;
	logic [63:0] tot64, prod, combined;

	always_comb begin
		r_op     = fraction & FRAC_MASK;
		tot64    = 64'(total);
		b_op     = lo_done_q ? tot64[63:32] : tot64[31:0];
		prod     = {32'd0, r_op} * {32'd0, b_op};
		combined = (hi_q << (32 - FRACTION_BITS)) + (lo_q >> FRACTION_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_done_q <= 1'b0;
			hi_done_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			lo_done_q <= start;
			hi_done_q <= lo_done_q;
			done_q    <= hi_done_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start)     lo_q     <= prod;
		if (lo_done_q) hi_q     <= prod;
		if (hi_done_q) target_q <= SUM_BITS'(combined);
	end

	assign rsp.done   = done_q;
	assign rsp.target = target_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !lo_done_q && !hi_done_q && !done_q)
		else $error("scale restarted while busy");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({lo_done_q, hi_done_q, done_q}))
		else $error("scale phases overlap");

	a_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (target_q < total) || (total == '0))
		else $error("scaled target not below total");

endmodule
`default_nettype wire

>>> tb/tb.sv
module tb import wes_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// DUT hookup
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	weighted_event_sum_tree dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// Shadow copy of the tree: heap order, root at node 0, leaf j at PADDED-1+j.
	logic [SUM_BITS-1:0] shadow_sum [NODE_COUNT];
	logic [COUNT_W-1:0]  shadow_count;

	req_t pending_req [$];   // requests not yet handed to the driver
	rsp_t expected_rsp [$];  // predicted results, oldest first

	// bookkeeping
	int unsigned mismatches = 0;
	int unsigned accepted = 0;
	int unsigned results_seen = 0;
	int unsigned n_set = 0, n_select = 0, n_clear = 0, n_nop = 0, n_event = 0;
	int unsigned peak_count = 0;
	logic [TOTAL_W-1:0] peak_total = '0;
	logic sent_flag = 1'b0;
	rsp_t want;
	rsp_t predicted;

	// pacing
	logic [15:0] cycle_count = '0;
	logic steady;
	int unsigned req_gap = 0;
	int unsigned rsp_stall = 0;
	logic hold_off = 1'b0;
	logic hold_done = 1'b0;
	int unsigned hold_cycles = 0;

	// Roughly a quarter of the time neither side idles at all.
	assign steady = (cycle_count[10:9] == 2'b11);

	// Apply one request to the shadow tree and return the result it should produce.
	function automatic rsp_t tree_apply(req_t r);
		rsp_t o;
		int unsigned n;
		logic [SUM_BITS-1:0] w;
		logic [SUM_BITS-1:0] goal;
		logic [SUM_BITS+FRACTION_BITS-1:0] prod;
		o = '0;
		case (r.operation)
			OP_SET: begin
				if (r.leaf_index < LEAF_COUNT) begin
					n = PADDED - 1 + r.leaf_index;
					w = SUM_BITS'(r.weight & WEIGHT_MASK);
					if (shadow_sum[n] != '0)
						shadow_count = shadow_count - 1'b1;
					if (w != '0)
						shadow_count = shadow_count + 1'b1;
					shadow_sum[n] = w;
					// re-sum every ancestor on the way up
					while (n > 0) begin
						n = (n - 1) / 2;
						shadow_sum[n] = shadow_sum[2*n+1] + shadow_sum[2*n+2];
					end
				end
			end
			OP_SELECT: begin
				if (shadow_sum[0] != '0) begin
					// target = floor(r * total / 2^FRACTION_BITS), exact product
					prod = (SUM_BITS+FRACTION_BITS)'(r.random_fraction & FRAC_MASK) *
					       (SUM_BITS+FRACTION_BITS)'(shadow_sum[0]);
					goal = SUM_BITS'(prod >> FRACTION_BITS);
					n = 0;
					// strict less-than: zero-weight leaves can never be picked
					while (n < PADDED - 1) begin
						if (goal < shadow_sum[2*n+1]) begin
							n = 2*n + 1;
						end else begin
							goal = goal - shadow_sum[2*n+1];
							n = 2*n + 2;
						end
					end
					o.event_valid = 1'b1;
					o.event_index = IDX_W'(n - (PADDED - 1));
				end
			end
			OP_CLEAR: begin
				for (int k = 0; k < NODE_COUNT; k++)
					shadow_sum[k] = '0;
				shadow_count = '0;
			end
			default: ;
		endcase
		o.total_weight = TOTAL_W'(shadow_sum[0]);
		o.active_count = shadow_count;
		return o;
	endfunction

	task automatic queue_req(op_t op, logic [IDX_W-1:0] idx, logic [FIELD_W-1:0] w,
			logic [FIELD_W-1:0] frac);
		req_t r;
		r.operation = op;
		r.leaf_index = idx;
		r.weight = w;
		r.random_fraction = frac;
		pending_req.push_back(r);
	endtask

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
		mismatches++;
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
			$time, what, got, exp_val);
	endtask

	// Idle length: mostly none, some short, a few long.
	function automatic int unsigned idle_len(int unsigned calm_pct);
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(99);
		if (r < calm_pct)
			return 0;
		if (r < 96)
			return $urandom_range(1, 4);
		return $urandom_range(12, 50);
	endfunction

	function automatic logic [IDX_W-1:0] pick_leaf();
		int unsigned r;
		r = $urandom_range(99);
		// hot leaves at both ends get rewritten often, so weights go on and off
		if (r < 25)
			return IDX_W'($urandom_range(15));
		if (r < 35)
			return IDX_W'(LEAF_COUNT - 1 - $urandom_range(15));
		return IDX_W'($urandom_range(LEAF_COUNT - 1));
	endfunction

	function automatic logic [FIELD_W-1:0] pick_weight();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		if (r < 30)
			return '1;
		if (r < 60)
			return FIELD_W'($urandom_range(1, 255));
		return $urandom;
	endfunction

	function automatic logic [FIELD_W-1:0] pick_fraction();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return $urandom;
	endfunction

	task automatic build_stimulus();
		int unsigned k;
		// select on an empty tree, then a no-op
		queue_req(OP_SELECT, '0, '0, $urandom);
		queue_req(OP_NOP, '1, '1, '1);
		// two full-scale leaves at the extremes of the index range
		queue_req(OP_SET, '0, '1, '0);
		queue_req(OP_SET, '1, '1, '1);
		queue_req(OP_SELECT, '0, '0, '0);
		queue_req(OP_SELECT, '1, '1, '1);
		// half scale lands exactly on the left sum: must turn right
		queue_req(OP_SELECT, '0, '0, 32'h8000_0000);
		queue_req(OP_SELECT, '0, '0, 32'h7FFF_FFFF);
		queue_req(OP_SET, 10'd512, 32'd1, '0);
		// positive to zero, zero to zero, positive to positive
		queue_req(OP_SET, '0, '0, '1);
		queue_req(OP_SET, '0, '0, '0);
		queue_req(OP_SET, '1, 32'd1, '0);
		// leaf 0 is now zero and must be skipped
		queue_req(OP_SELECT, '0, '0, '0);
		queue_req(OP_SELECT, '0, '0, '1);
		queue_req(OP_SET, 10'h2AA, 32'h5555_5555, 32'hAAAA_AAAA);
		queue_req(OP_SET, 10'h155, 32'hAAAA_AAAA, 32'h5555_5555);
		queue_req(OP_SELECT, 10'h155, 32'h5555_5555, 32'h5555_5555);
		queue_req(OP_SELECT, 10'h2AA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
		queue_req(OP_NOP, 10'h2AA, 32'h5555_5555, 32'hAAAA_AAAA);
		queue_req(OP_CLEAR, '1, '1, '1);
		queue_req(OP_SELECT, '0, '0, '1);
		queue_req(OP_NOP, '0, '0, '0);

		// random traffic; the first stretch loads heavy weights to push the total high
		for (int i = 0; i < 700; i++) begin
			k = $urandom_range(999);
			if (i < 120) begin
				if (k < 700)
					queue_req(OP_SET, IDX_W'($urandom_range(LEAF_COUNT - 1)),
						32'hFFFF_FFFF - $urandom_range(15), $urandom);
				else
					queue_req(OP_SELECT, pick_leaf(), $urandom, pick_fraction());
			end else if (k < 15) begin
				queue_req(OP_CLEAR, pick_leaf(), $urandom, $urandom);
			end else if (k < 45) begin
				queue_req(OP_NOP, pick_leaf(), $urandom, $urandom);
			end else if (k < 520) begin
				queue_req(OP_SET, pick_leaf(), pick_weight(), $urandom);
			end else begin
				queue_req(OP_SELECT, pick_leaf(), $urandom, pick_fraction());
			end
		end
	endtask

	always @(posedge clk)
		cycle_count <= cycle_count + 1'b1;

	// Request driver: new request only once the previous one was taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || sent_flag) begin
			if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (pending_req.size() != 0) begin
				req <= pending_req.pop_front();
				req_valid <= 1'b1;
				req_gap = idle_len(65);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		if (!arst_n || hold_off) begin
			rsp_ready <= 1'b0;
		end else if (rsp_stall > 0) begin
			rsp_stall--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_stall = idle_len(85);
			rsp_ready <= 1'b1;
		end
	end

	// One long hold-off on the result side, so the block backs up into its input.
	always @(posedge clk) begin
		if (!hold_off && !hold_done && accepted >= 300) begin
			hold_off <= 1'b1;
			hold_cycles = 0;
		end else if (hold_off) begin
			hold_cycles++;
			if (hold_cycles == 600) begin
				hold_off <= 1'b0;
				hold_done <= 1'b1;
			end
		end
	end

	// Monitor: check results first, then predict for a request taken at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			sent_flag <= req_valid && req_ready;
			if (rsp_valid && rsp_ready) begin
				results_seen++;
				if (expected_rsp.size() == 0) begin
					flag_mismatch("result with nothing pending", 64'(rsp), '0);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.event_valid !== want.event_valid)
						flag_mismatch("event_valid", 64'(rsp.event_valid),
							64'(want.event_valid));
					if (rsp.event_index !== want.event_index)
						flag_mismatch("event_index", 64'(rsp.event_index),
							64'(want.event_index));
					if (rsp.total_weight !== want.total_weight)
						flag_mismatch("total_weight", 64'(rsp.total_weight),
							64'(want.total_weight));
					if (rsp.active_count !== want.active_count)
						flag_mismatch("active_count", 64'(rsp.active_count),
							64'(want.active_count));
				end
			end
			if (req_valid && req_ready) begin
				predicted = tree_apply(req);
				expected_rsp.push_back(predicted);
				accepted <= accepted + 1;
				case (req.operation)
					OP_SET:    n_set++;
					OP_SELECT: n_select++;
					OP_CLEAR:  n_clear++;
					default:   n_nop++;
				endcase
				if (predicted.event_valid)
					n_event++;
				if (predicted.active_count > peak_count)
					peak_count = predicted.active_count;
				if (predicted.total_weight > peak_total)
					peak_total = predicted.total_weight;
			end
		end
	end

	// Main sequence: reset, let the driver drain the request list, then settle.
	initial begin
		// the tree comes out of reset empty
		for (int k = 0; k < NODE_COUNT; k++)
			shadow_sum[k] = '0;
		shadow_count = '0;
		build_stimulus();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_req.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		// a select is the slowest non-clear request; leave room for a stray result
		repeat (40) @(posedge clk);

		$display("covered %0d requests: %0d sets, %0d selects (%0d picked a leaf), %0d clears, %0d no-ops",
			accepted, n_set, n_select, n_event, n_clear, n_nop);
		$display("peak active leaves %0d, peak total 0x%0h, %0d results checked, %0d mismatches",
			peak_count, peak_total, results_seen, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog: far beyond even a run made of nothing but clears with worst-case idling.
	initial begin
		#80_000_000;
		$display("timeout after %0d requests, %0d results", accepted, results_seen);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> files.f
src/wes_pkg.sv
src/wes_scale.sv
src/weighted_event_sum_tree.sv
tb/tb.sv
